/* src/dqip_pkg.sv */
// Shared types and constants for the dotted-quad IPv4 detector.
// No dependencies; imported by dqip_scan, dotted_quad_ipv4_detector and the dv files.
`timescale 1ns / 1ps
`default_nettype none

package dqip_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Octet arithmetic
    localparam int         VALUE_W     = 9;
    localparam int         PROD_W      = 13;
    localparam int         NUM_OCTETS  = 4;
    localparam logic [1:0] LAST_OCTET  = 2'd3;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 9'd511;
    localparam logic [VALUE_W-1:0] OCTET_MAX = 9'd255;

    // Noise patterns
    localparam logic [VALUE_W-1:0] LOOPBACK_FIRST = 9'd127;
    localparam logic [VALUE_W-1:0] VERSION_FIRST  = 9'd2;
    localparam logic [VALUE_W-1:0] VERSION_SECOND = 9'd5;

    typedef logic [VALUE_W-1:0] octet_t;

    // Per-string scan control state
    typedef struct packed {
        logic [1:0]            idx;
        logic [NUM_OCTETS-1:0] opened;
        logic                  closed;
        logic                  stopped;
        logic                  rejected;
    } scan_state_t;

    // Verdict for one string
    typedef struct packed {
        logic        is_ip;
        logic [31:0] address;
    } verdict_t;

endpackage

`default_nettype wire

/* src/dqip_scan.sv */
// Per-byte scanner: octet index, opened flags, saturating octet values,
// and the end-of-string verdict. Depends on dqip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dqip_scan
    import dqip_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,        // consume one byte this cycle
    input  wire logic [7:0] ch,
    input  wire logic       last,
    input  wire logic       show_noise,
    output verdict_t        verdict      // valid in the cycle the last byte steps
);

    scan_state_t st_reg, st_next, st_upd;
    octet_t      val_reg [NUM_OCTETS];
    octet_t      val_next [NUM_OCTETS];
    octet_t      val_upd [NUM_OCTETS];
    octet_t      cur;
    logic [PROD_W-1:0] prod;
    logic        is_digit;
    logic        noise;
    logic        in_range;

    // Multiply current octet by ten and add the digit
    assign cur  = val_reg[st_reg.idx];
    assign prod = {1'b0, cur, 3'b000} + {3'b000, cur, 1'b0} + {9'b0, ch[3:0]};
    assign is_digit = ch inside {[CH_ZERO:CH_NINE]};

    // Apply one byte to the scan state
    always_comb
    begin
        st_upd = st_reg;
        for (int i = 0; i < NUM_OCTETS; i++)
        begin
            val_upd[i] = val_reg[i];
        end
        if (!st_reg.stopped && !st_reg.rejected)
        begin
            if (ch == CH_NUL)
            begin
                st_upd.stopped = 1'b1;
            end
            else
            begin
                st_upd.opened[st_reg.idx] = 1'b1;
                if (ch == CH_DOT)
                begin
                    if (st_reg.idx == LAST_OCTET)
                    begin
                        st_upd.rejected = 1'b1;
                        st_upd.stopped  = 1'b1;
                    end
                    else
                    begin
                        st_upd.idx    = st_reg.idx + 2'd1;
                        st_upd.closed = 1'b0;
                    end
                end
                else if (is_digit)
                begin
                    if (!st_reg.closed)
                    begin
                        val_upd[st_reg.idx] = (prod > {4'b0, VALUE_MAX}) ?
                                              VALUE_MAX : prod[VALUE_W-1:0];
                    end
                end
                else
                begin
                    st_upd.closed  = 1'b1;
                    st_upd.stopped = 1'b1;
                end
            end
        end
    end

    // Judge the updated state
    always_comb
    begin
        noise = ((val_upd[0] == LOOPBACK_FIRST) && (val_upd[1] == '0) &&
                 (val_upd[2] == '0) && (val_upd[3] == 9'd1)) ||
                ((val_upd[0] == OCTET_MAX) && (val_upd[1] == OCTET_MAX) &&
                 (val_upd[2] == OCTET_MAX) && (val_upd[3] == OCTET_MAX)) ||
                (val_upd[3] == '0) ||
                ((val_upd[0] == VERSION_FIRST) && (val_upd[1] == VERSION_SECOND));
        in_range = (val_upd[0] != '0) && (val_upd[0] <= OCTET_MAX) &&
                   (val_upd[1] <= OCTET_MAX) && (val_upd[2] <= OCTET_MAX) &&
                   (val_upd[3] <= OCTET_MAX);
        verdict.is_ip = !st_upd.rejected && (&st_upd.opened) && in_range &&
                        (show_noise || !noise);
        verdict.address = verdict.is_ip ?
                          {val_upd[0][7:0], val_upd[1][7:0],
                           val_upd[2][7:0], val_upd[3][7:0]} : 32'd0;
    end

    // Advance on each byte; clear after the last one
    always_comb
    begin
        st_next = st_reg;
        for (int i = 0; i < NUM_OCTETS; i++)
        begin
            val_next[i] = val_reg[i];
        end
        if (step)
        begin
            if (last)
            begin
                st_next = '0;
                for (int i = 0; i < NUM_OCTETS; i++)
                begin
                    val_next[i] = '0;
                end
            end
            else
            begin
                st_next = st_upd;
                for (int i = 0; i < NUM_OCTETS; i++)
                begin
                    val_next[i] = val_upd[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
            for (int i = 0; i < NUM_OCTETS; i++)
            begin
                val_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            for (int i = 0; i < NUM_OCTETS; i++)
            begin
                val_reg[i] <= val_next[i];
            end
        end
    end

endmodule

`default_nettype wire

/* src/dotted_quad_ipv4_detector.sv */
// Top level of the dotted-quad IPv4 detector: stream ports, input and
// result registers, noise-filter register. Depends on dqip_pkg, dqip_scan.
`timescale 1ns / 1ps
`default_nettype none

// Takes a string one byte per request on the slave stream and, for the byte
// flagged by s_tlast, emits one result on the master stream: m_tuser says
// whether the string is a dotted-quad IPv4 address and m_tdata carries the
// address (first octet in the top byte, zero when not an address). Bytes
// without s_tlast produce no result. One byte is taken every clock cycle
// unless stalled, through input and result registers. The only stall
// comes from the output register: a last byte waits in the input register
// while a previous result is still unclaimed. cfg_data bit 0 set to 1 shows
// loopback, broadcast, zero-host and "2.5." addresses that are otherwise
// filtered; write it only while no string is in flight.
module dotted_quad_ipv4_detector
    import dqip_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,    // [0] show_common_noise
    // byte stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] ch
    input  wire logic        s_tlast,     // last
    // verdict stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,     // [31:0] address
    output logic             m_tuser      // [0] is_ip
);

    logic        noise_reg;
    logic        in_valid_reg;
    logic [7:0]  in_ch_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    logic [31:0] out_addr_reg;
    logic        out_is_ip_reg;
    logic        advance;
    logic        out_free;
    verdict_t    verdict;

    // Hold a last byte while the result register is still occupied
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    dqip_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .ch         (in_ch_reg),
        .last       (in_last_reg),
        .show_noise (noise_reg),
        .verdict    (verdict)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            noise_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_is_ip_reg <= verdict.is_ip;
            out_addr_reg  <= verdict.address;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_is_ip_reg;

endmodule

`default_nettype wire

/* dv/dqip_verdict_check.sv */
// Checker for the dotted-quad IPv4 detector: watches the config, byte and
// verdict channels, predicts each verdict and compares it. Depends on dqip_pkg.
`timescale 1ns / 1ps

module dqip_verdict_check
    import dqip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    output int          mismatches,
    output int          outstanding
);

    // Predicted scan state of the string in progress
    scan_state_t scan;
    octet_t      octet_val [NUM_OCTETS];
    logic        show_noise;

    // Verdicts predicted but not yet seen on the master side
    verdict_t    verdict_q [$];
    int          errors = 0;

    // Clear the per-string state
    task automatic clear_scan();
        scan = '0;
        for (int i = 0; i < NUM_OCTETS; i++)
        begin
            octet_val[i] = '0;
        end
    endtask

    // Advance the scan by one byte of the string
    task automatic scan_char(input logic [7:0] c);
        int prod;
        if (scan.stopped || scan.rejected)
            return;
        if (c == CH_NUL)
        begin
            scan.stopped = 1'b1;
            return;
        end
        scan.opened[scan.idx] = 1'b1;
        if (c == CH_DOT)
        begin
            // a dot in the last octet kills the whole string
            if (scan.idx == LAST_OCTET)
            begin
                scan.rejected = 1'b1;
                scan.stopped  = 1'b1;
            end
            else
            begin
                scan.idx    = scan.idx + 2'd1;
                scan.closed = 1'b0;
            end
        end
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            if (!scan.closed)
            begin
                prod = int'(octet_val[scan.idx]) * 10 + (int'(c) - int'(CH_ZERO));
                octet_val[scan.idx] = (prod > int'(VALUE_MAX)) ? VALUE_MAX : octet_t'(prod);
            end
        end
        else
        begin
            scan.closed  = 1'b1;
            scan.stopped = 1'b1;
        end
    endtask

    // Judge the finished string
    function automatic verdict_t judge_string();
        verdict_t v;
        logic     ok;
        v  = '0;
        ok = !scan.rejected && (&scan.opened);
        if (!show_noise)
        begin
            if (octet_val[0] == LOOPBACK_FIRST && octet_val[1] == 0 &&
                octet_val[2] == 0 && octet_val[3] == 1)
                ok = 1'b0;
            if (octet_val[0] == OCTET_MAX && octet_val[1] == OCTET_MAX &&
                octet_val[2] == OCTET_MAX && octet_val[3] == OCTET_MAX)
                ok = 1'b0;
            if (octet_val[3] == 0)
                ok = 1'b0;
            if (octet_val[0] == VERSION_FIRST && octet_val[1] == VERSION_SECOND)
                ok = 1'b0;
        end
        if (octet_val[0] == 0 || octet_val[0] > OCTET_MAX)
            ok = 1'b0;
        if (octet_val[1] > OCTET_MAX || octet_val[2] > OCTET_MAX || octet_val[3] > OCTET_MAX)
            ok = 1'b0;
        v.is_ip = ok;
        if (ok)
            v.address = {octet_val[0][7:0], octet_val[1][7:0],
                         octet_val[2][7:0], octet_val[3][7:0]};
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t exp;
        if (!rst_n)
        begin
            clear_scan();
            show_noise = 1'b0;
            verdict_q.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            // Compare a delivered verdict with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected verdict: expected none, got is_ip=%0b address=%08h",
                             $time, m_tuser, m_tdata);
                end
                else
                begin
                    exp = verdict_q.pop_front();
                    if (m_tuser !== exp.is_ip)
                    begin
                        errors++;
                        $display("%0t: is_ip mismatch: expected %0b, got %0b",
                                 $time, exp.is_ip, m_tuser);
                    end
                    if (m_tdata !== exp.address)
                    begin
                        errors++;
                        $display("%0t: address mismatch: expected %08h, got %08h",
                                 $time, exp.address, m_tdata);
                    end
                end
            end

            // Track the noise filter register
            if (cfg_valid && cfg_ready)
                show_noise = cfg_data;

            // Scan an accepted byte; predict a verdict on the last one
            if (s_tvalid && s_tready)
            begin
                scan_char(s_tdata);
                if (s_tlast)
                begin
                    verdict_q.push_back(judge_string());
                    clear_scan();
                end
            end

            outstanding <= verdict_q.size();
            mismatches  <= errors;
        end
    end

endmodule

/* dv/tb_dotted_quad_ipv4_detector.sv */
// Testbench top for the dotted-quad IPv4 detector: clock, reset, byte
// strings and config writes. Depends on dqip_pkg, dqip_verdict_check and the RTL.
`timescale 1ns / 1ps

module tb_dotted_quad_ipv4_detector
    import dqip_pkg::*;
();

    localparam int HALF_PERIOD = 6;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    int          fail_count;
    int          outstanding;
    int          idle_pct;
    int          cycles = 0;

    // Bytes of the string about to be sent
    logic [7:0]  str_bytes [$];

    dotted_quad_ipv4_detector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    dqip_verdict_check verdict_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (fail_count),
        .outstanding (outstanding)
    );

    always #HALF_PERIOD clk = ~clk;

    // Stall the verdict side at random
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            str_bytes.push_back(s[i]);
        end
    endtask

    // Send one byte, with random gaps before it
    task automatic send_byte(input logic [7:0] c, input logic is_last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Send the queued string, flagging its final byte
    task automatic send_text();
        for (int i = 0; i < str_bytes.size(); i++)
        begin
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
        end
        str_bytes.delete();
    endtask

    // Hold until every predicted verdict has come out, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_show_noise(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Pick a byte that stops the scan: neither digit, dot nor zero
    function automatic logic [7:0] stop_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_DOT || (c >= CH_ZERO && c <= CH_NINE));
        return c;
    endfunction

    // Random octet value; negative means leave the octet empty
    function automatic int random_octet();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return $urandom_range(0, 255);
        else if (r < 14)
            return $urandom_range(0, 9);
        else if (r == 14)
            return $urandom_range(256, 999);
        else if (r == 15)
            return $urandom_range(1000, 99999);
        else if (r == 16)
            return -1;
        return $urandom_range(0, 255);
    endfunction

    // Build one random string: mostly address-shaped, some plain noise
    task automatic make_random_string();
        int oct [5];
        int pick;
        int n_octets;
        int tail;
        str_bytes.delete();
        if ($urandom_range(0, 99) < 12)
        begin
            repeat ($urandom_range(1, 8)) str_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        for (int i = 0; i < 5; i++)
        begin
            oct[i] = random_octet();
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0:
            begin
                oct[0] = 127;
                oct[1] = 0;
                oct[2] = 0;
                oct[3] = 1;
            end
            1:
            begin
                oct[0] = 255;
                oct[1] = 255;
                oct[2] = 255;
                oct[3] = 255;
            end
            2: oct[3] = 0;
            3:
            begin
                oct[0] = 2;
                oct[1] = 5;
            end
            default: ;
        endcase
        // mostly four octets; now and then too few or one too many
        n_octets = 4;
        if ($urandom_range(0, 9) == 0)
            n_octets = ($urandom_range(0, 1) == 1) ? 5 : $urandom_range(1, 3);
        for (int i = 0; i < n_octets; i++)
        begin
            if (i > 0)
                str_bytes.push_back(CH_DOT);
            if (oct[i] >= 0)
            begin
                if ($urandom_range(0, 15) == 0)
                    str_bytes.push_back(CH_ZERO);
                push_str($sformatf("%0d", oct[i]));
            end
        end
        // trailing junk after a stop, a terminator, or one stray byte
        tail = $urandom_range(0, 9);
        if (tail == 0)
        begin
            str_bytes.push_back(stop_char());
            repeat ($urandom_range(0, 3)) str_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (tail == 1)
        begin
            str_bytes.push_back(CH_NUL);
            repeat ($urandom_range(0, 3)) str_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (tail == 2)
            str_bytes.push_back(8'($urandom_range(0, 255)));
        if (str_bytes.size() == 0)
            str_bytes.push_back(CH_DOT);
    endtask

    task automatic run_random(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes)
        begin
            make_random_string();
            sent += str_bytes.size();
            send_text();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        idle_pct  = 10;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lone terminator, empty octets, saturation, missing octet,
        // dot in the last octet, lone stopping byte
        str_bytes.push_back(CH_NUL);
        send_text();
        push_str("1...9");
        send_text();
        push_str("999...1");
        send_text();
        push_str("1.2.3");
        send_text();
        push_str("1...1.");
        send_text();
        str_bytes.push_back(8'hFF);
        send_text();

        // Random phases, flipping the noise filter between them
        wait_drained();
        write_show_noise(1'b1);
        run_random(275);

        wait_drained();
        write_show_noise(1'b0);
        idle_pct = 0;
        run_random(275);

        wait_drained();
        write_show_noise(1'b1);
        idle_pct = 10;
        run_random(275);

        wait_drained();
        write_show_noise(1'b0);
        run_random(275);

        wait_drained();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
src/dqip_pkg.sv
src/dqip_scan.sv
src/dotted_quad_ipv4_detector.sv
dv/dqip_verdict_check.sv
dv/tb_dotted_quad_ipv4_detector.sv
